// ----- hw/rtl/htpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared widths, codes, constants and types of the heading turn PID drive.
package htpd_pkg;

    localparam int HEADING_W  = 12;
    localparam int TIME_W     = 32;
    localparam int ERR_W      = 12;
    localparam int MAG_W      = 11;
    localparam int DT_W       = 9;
    localparam int INTEG_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int PWM_W      = 8;
    localparam int DIR_W      = 2;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 22;
    localparam int PROD_W     = 50;
    localparam int NUM_W      = 50;
    localparam int ABS_W      = 49;
    localparam int DEN_W      = 31;
    localparam int QUOT_W     = 8;
    localparam int BIT_W      = 3;
    localparam int OP_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Time step window in ms
    localparam logic [DT_W-1:0] DT_MIN_MS = 9'd10;
    localparam logic [DT_W-1:0] DT_MAX_MS = 9'd500;

    // Integral bound: 300 degree-seconds in tenth-degree * ms
    localparam logic signed [INTEG_W-1:0] INTEG_LIMIT = 24'sd3000000;

    // Heading wrap in tenths
    localparam logic signed [ERR_W:0]   WRAP_HALF = 13'sd1800;
    localparam logic signed [ERR_W:0]   WRAP_FULL = 13'sd3600;
    localparam logic signed [ERR_W-1:0] ERR_LIMIT = 12'sd1800;

    // Scale factors of the fixed-point PID sum
    localparam logic [MUL_B_W-1:0] K_MS  = 22'd1000;
    localparam logic [MUL_B_W-1:0] K_US  = 22'd1000000;
    localparam logic [MUL_B_W-1:0] K_DEN = 22'd2560000;

    localparam logic [PWM_W-1:0] STRONG_CEILING = 8'd255;

    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_ZONE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_FLOOR   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_CEILING = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_FLOOR = 4'd7;

    // Datapath operations, one per controller step
    localparam logic [OP_W-1:0] OP_IDLE     = 4'd0;
    localparam logic [OP_W-1:0] OP_LATCH    = 4'd1;
    localparam logic [OP_W-1:0] OP_ERR      = 4'd2;
    localparam logic [OP_W-1:0] OP_DT       = 4'd3;
    localparam logic [OP_W-1:0] OP_ERR_DT   = 4'd4;
    localparam logic [OP_W-1:0] OP_SCALE_MS = 4'd5;
    localparam logic [OP_W-1:0] OP_TERM_P   = 4'd6;
    localparam logic [OP_W-1:0] OP_INTEG_DT = 4'd7;
    localparam logic [OP_W-1:0] OP_TERM_I   = 4'd8;
    localparam logic [OP_W-1:0] OP_DIFF     = 4'd9;
    localparam logic [OP_W-1:0] OP_SCALE_US = 4'd10;
    localparam logic [OP_W-1:0] OP_DEN      = 4'd11;
    localparam logic [OP_W-1:0] OP_MAG      = 4'd12;
    localparam logic [OP_W-1:0] OP_SAT      = 4'd13;
    localparam logic [OP_W-1:0] OP_DIV      = 4'd14;
    localparam logic [OP_W-1:0] OP_CLAMP    = 4'd15;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [MAG_W-1:0]  deadband_tenths;
        logic [MAG_W-1:0]  strong_zone_tenths;
        logic [PWM_W-1:0]  fine_floor;
        logic [PWM_W-1:0]  fine_ceiling;
        logic [PWM_W-1:0]  strong_floor;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_p:             16'd768,
        gain_i:             16'd26,
        gain_d:             16'd0,
        deadband_tenths:    11'd80,
        strong_zone_tenths: 11'd400,
        fine_floor:         8'd110,
        fine_ceiling:       8'd130,
        strong_floor:       8'd180
    };

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BIT_W-1:0] div_bit;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic in_deadband;
        logic quot_sat;
    } t_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/htpd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels: control step in, drive result out.
interface htpd_in_if;
    import htpd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [HEADING_W-1:0] target_heading;
    logic [HEADING_W-1:0] measured_heading;
    logic [TIME_W-1:0]    now_ms;
    logic                 restart;

    modport source (output valid, output target_heading, output measured_heading,
                    output now_ms, output restart, input ready);
    modport sink   (input valid, input target_heading, input measured_heading,
                    input now_ms, input restart, output ready);
endinterface

interface htpd_out_if;
    import htpd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [PWM_W-1:0]        drive_pwm;
    logic [DIR_W-1:0]        turn_dir;
    logic signed [ERR_W-1:0] wrapped_error;

    modport source (output valid, output drive_pwm, output turn_dir,
                    output wrapped_error, input ready);
    modport sink   (input valid, input drive_pwm, input turn_dir,
                    input wrapped_error, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/htpd_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath: error wrap, PID state, shared multiplier, quotient and PWM window.
module htpd_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire htpd_pkg::t_cfg               i_cfg,
    input  wire htpd_pkg::t_cmd               i_cmd,
    output htpd_pkg::t_sts                    o_sts,
    input  wire logic [htpd_pkg::HEADING_W-1:0] i_target_heading,
    input  wire logic [htpd_pkg::HEADING_W-1:0] i_measured_heading,
    input  wire logic [htpd_pkg::TIME_W-1:0]  i_now_ms,
    input  wire logic                         i_restart,
    output logic [htpd_pkg::PWM_W-1:0]        o_drive_pwm,
    output logic [htpd_pkg::DIR_W-1:0]        o_turn_dir,
    output logic signed [htpd_pkg::ERR_W-1:0] o_wrapped_error
);
    import htpd_pkg::*;

    // Latched step
    logic [HEADING_W-1:0] r_tgt;
    logic [HEADING_W-1:0] r_meas;
    logic [TIME_W-1:0]    r_now;
    logic                 r_restart;

    // Controller history
    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic [TIME_W-1:0]         r_prev_time;

    // Working registers
    logic signed [ERR_W-1:0]  r_err;
    logic [DT_W-1:0]          r_dt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [NUM_W-1:0]  r_num;
    logic [ABS_W-1:0]         r_mag;
    logic [DEN_W-1:0]         r_den;
    logic [ABS_W-1:0]         r_rem;
    logic [QUOT_W-1:0]        r_quot;
    logic                     r_quot_sat;
    logic [PWM_W-1:0]         r_pwm;
    logic [DIR_W-1:0]         r_dir;

    logic signed [ERR_W:0]           head_diff;
    logic signed [ERR_W:0]           head_wrap;
    logic signed [ERR_W-1:0]         err_abs;
    logic [MAG_W-1:0]                mag_err;
    logic                            in_deadband;
    logic [TIME_W-1:0]               elapsed;
    logic [DT_W-1:0]                 dt_clamped;
    logic signed [INTEG_W:0]         integ_sum;
    logic signed [INTEG_W-1:0]       integ_clamped;
    logic signed [ERR_W:0]           err_step;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]              mul_b;
    logic                            mul_en;
    logic signed [MUL_A_W+MUL_B_W:0] mul_full;
    logic signed [NUM_W-1:0]         num_abs;
    logic [ABS_W-1:0]                den_top;
    logic                            quot_sat;
    logic [ABS_W-1:0]                den_shift;
    logic                            zone_strong;
    logic [PWM_W-1:0]                win_lo;
    logic [PWM_W-1:0]                win_hi;
    logic [PWM_W-1:0]                pwm_clamped;
    logic [DIR_W-1:0]                dir_next;

    // Wrap target minus measured once into plus or minus 180 degrees
    always_comb begin
        head_diff = $signed({1'b0, r_tgt}) - $signed({1'b0, r_meas});
        if (head_diff > WRAP_HALF) begin
            head_wrap = head_diff - WRAP_FULL;
        end else if (head_diff < -WRAP_HALF) begin
            head_wrap = head_diff + WRAP_FULL;
        end else begin
            head_wrap = head_diff;
        end
    end

    assign err_abs     = r_err[ERR_W-1] ? -r_err : r_err;
    assign mag_err     = err_abs[MAG_W-1:0];
    assign in_deadband = (mag_err <= i_cfg.deadband_tenths);

    // Elapsed time modulo 2^32, clamped to the step window
    always_comb begin
        elapsed = r_now - r_prev_time;
        if (elapsed < TIME_W'(DT_MIN_MS)) begin
            dt_clamped = DT_MIN_MS;
        end else if (elapsed > TIME_W'(DT_MAX_MS)) begin
            dt_clamped = DT_MAX_MS;
        end else begin
            dt_clamped = elapsed[DT_W-1:0];
        end
    end

    // Integral update; r_prod holds err * dt at this point
    always_comb begin
        integ_sum = $signed({r_integral[INTEG_W-1], r_integral}) + $signed(r_prod[INTEG_W:0]);
        if (integ_sum > (INTEG_W+1)'(INTEG_LIMIT)) begin
            integ_clamped = INTEG_LIMIT;
        end else if (integ_sum < -((INTEG_W+1)'(INTEG_LIMIT))) begin
            integ_clamped = -INTEG_LIMIT;
        end else begin
            integ_clamped = integ_sum[INTEG_W-1:0];
        end
    end

    assign err_step = (ERR_W+1)'(r_err) - (ERR_W+1)'(r_prev_err);

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_ERR_DT: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(r_dt);
            end
            OP_SCALE_MS: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = K_MS;
            end
            OP_TERM_P: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'(i_cfg.gain_p);
            end
            OP_INTEG_DT: begin
                mul_a = MUL_A_W'(r_integral);
                mul_b = MUL_B_W'(r_dt);
            end
            OP_TERM_I: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'(i_cfg.gain_i);
            end
            OP_DIFF: begin
                mul_a = MUL_A_W'(err_step);
                mul_b = MUL_B_W'(i_cfg.gain_d);
            end
            OP_SCALE_US: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = K_US;
            end
            OP_DEN: begin
                mul_a = MUL_A_W'(r_dt);
                mul_b = K_DEN;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_en   = i_cmd.op inside {[OP_ERR_DT:OP_DEN]};
    assign mul_full = mul_a * $signed({1'b0, mul_b});

    assign num_abs   = r_num[NUM_W-1] ? -r_num : r_num;
    assign den_top   = ABS_W'({r_den, {QUOT_W{1'b0}}});
    assign quot_sat  = (r_mag >= den_top);
    assign den_shift = ABS_W'(r_den) << i_cmd.div_bit;

    // PWM window; a floor above the ceiling wins only for a quotient below the floor, else the ceiling wins
    always_comb begin
        zone_strong = (mag_err >= i_cfg.strong_zone_tenths);
        win_lo = zone_strong ? i_cfg.strong_floor : i_cfg.fine_floor;
        win_hi = zone_strong ? STRONG_CEILING : i_cfg.fine_ceiling;
        if (!r_quot_sat && (r_quot < win_lo)) begin
            pwm_clamped = win_lo;
        end else if (r_quot_sat || (r_quot > win_hi)) begin
            pwm_clamped = win_hi;
        end else begin
            pwm_clamped = r_quot;
        end
        dir_next = (r_err > 12'sd0) ? DIR_RIGHT : DIR_LEFT;
    end

    assign o_sts.in_deadband = in_deadband;
    assign o_sts.quot_sat    = quot_sat;

    // History kept across steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_prev_time <= '0;
        end else begin
            case (i_cmd.op)
                OP_ERR: begin
                    if (r_restart) begin
                        r_integral  <= '0;
                        r_prev_err  <= '0;
                        r_prev_time <= r_now;
                    end
                end
                OP_DT: begin
                    if (in_deadband) begin
                        r_integral <= '0;
                    end else begin
                        r_prev_time <= r_now;
                    end
                end
                OP_SCALE_MS: r_integral <= integ_clamped;
                OP_DIFF:     r_prev_err <= r_err;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
        case (i_cmd.op)
            OP_LATCH: begin
                r_tgt     <= i_target_heading;
                r_meas    <= i_measured_heading;
                r_now     <= i_now_ms;
                r_restart <= i_restart;
            end
            OP_ERR: r_err <= head_wrap[ERR_W-1:0];
            OP_DT: begin
                r_dt  <= dt_clamped;
                r_pwm <= '0;
                r_dir <= DIR_STOP;
            end
            OP_INTEG_DT: r_num <= r_prod;
            OP_DIFF:     r_num <= r_num + r_prod;
            OP_DEN:      r_num <= r_num + r_prod;
            OP_MAG: begin
                r_den <= r_prod[DEN_W-1:0];
                r_mag <= num_abs[ABS_W-1:0];
            end
            OP_SAT: begin
                r_rem      <= r_mag;
                r_quot     <= '0;
                r_quot_sat <= quot_sat;
            end
            OP_DIV: begin
                if (r_rem >= den_shift) begin
                    r_rem                 <= r_rem - den_shift;
                    r_quot[i_cmd.div_bit] <= 1'b1;
                end
            end
            OP_CLAMP: begin
                r_pwm <= pwm_clamped;
                r_dir <= dir_next;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            o_drive_pwm     <= r_pwm;
            o_turn_dir      <= r_dir;
            o_wrapped_error <= r_err;
        end
    end

`ifndef SYNTHESIS
    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integral <= INTEG_LIMIT) && (r_integral >= -INTEG_LIMIT))
        else $error("integral outside its bound");

    a_prev_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_err <= ERR_LIMIT) && (r_prev_err >= -ERR_LIMIT))
        else $error("stored error outside the wrap range");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_DIV) |-> (r_rem < (ABS_W'({r_den, 1'b0}) << i_cmd.div_bit)))
        else $error("quotient step with remainder too large");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/htpd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Controller: sequences one control step through the datapath.
module htpd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    input  wire htpd_pkg::t_sts i_sts,
    output htpd_pkg::t_cmd      o_cmd
);
    import htpd_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ERR      = 4'd1;
    localparam logic [3:0] S_DT       = 4'd2;
    localparam logic [3:0] S_ERR_DT   = 4'd3;
    localparam logic [3:0] S_SCALE_MS = 4'd4;
    localparam logic [3:0] S_TERM_P   = 4'd5;
    localparam logic [3:0] S_INTEG_DT = 4'd6;
    localparam logic [3:0] S_TERM_I   = 4'd7;
    localparam logic [3:0] S_DIFF     = 4'd8;
    localparam logic [3:0] S_SCALE_US = 4'd9;
    localparam logic [3:0] S_DEN      = 4'd10;
    localparam logic [3:0] S_MAG      = 4'd11;
    localparam logic [3:0] S_SAT      = 4'd12;
    localparam logic [3:0] S_DIV      = 4'd13;
    localparam logic [3:0] S_CLAMP    = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [BIT_W-1:0] r_bit;
    logic [BIT_W-1:0] n_bit;
    logic             r_out_valid;
    logic             n_out_valid;

    always_comb begin
        n_state        = r_state;
        n_bit          = r_bit;
        o_cmd.op       = OP_IDLE;
        o_cmd.div_bit  = r_bit;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_ERR;
                end
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_DT;
            end
            S_DT: begin
                o_cmd.op = OP_DT;
                n_state  = i_sts.in_deadband ? S_DONE : S_ERR_DT;
            end
            S_ERR_DT: begin
                o_cmd.op = OP_ERR_DT;
                n_state  = S_SCALE_MS;
            end
            S_SCALE_MS: begin
                o_cmd.op = OP_SCALE_MS;
                n_state  = S_TERM_P;
            end
            S_TERM_P: begin
                o_cmd.op = OP_TERM_P;
                n_state  = S_INTEG_DT;
            end
            S_INTEG_DT: begin
                o_cmd.op = OP_INTEG_DT;
                n_state  = S_TERM_I;
            end
            S_TERM_I: begin
                o_cmd.op = OP_TERM_I;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_SCALE_US;
            end
            S_SCALE_US: begin
                o_cmd.op = OP_SCALE_US;
                n_state  = S_DEN;
            end
            S_DEN: begin
                o_cmd.op = OP_DEN;
                n_state  = S_MAG;
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_SAT;
            end
            S_SAT: begin
                o_cmd.op = OP_SAT;
                if (i_sts.quot_sat) begin
                    n_state = S_CLAMP;
                end else begin
                    n_state = S_DIV;
                    n_bit   = '1;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_bit == '0) begin
                    n_state = S_CLAMP;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            S_CLAMP: begin
                o_cmd.op = OP_CLAMP;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_deadband_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DT && i_sts.in_deadband) |=> (r_state == S_DONE))
        else $error("deadband step did not go straight to the result");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("new result would overwrite a pending one");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/heading_turn_pid_drive.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Top level of the heading turn PID drive: configuration registers, controller, datapath.
//
// One control step is taken per transfer on i_item and answered by exactly one transfer on
// o_result. A step outside the deadband first runs the single shared 32x22 multiplier
// (error times dt, the three PID terms and the divisor), then eight restoring steps of the
// PWM quotient, one bit a cycle. When the quotient reaches 256 or more the quotient steps
// are skipped, and a step inside the deadband skips both and goes straight to the result.
// The result waits in an output register; if it has not been taken when the next result is
// ready, the controller holds until it is. Configuration registers are written with i_cfg_we,
// i_cfg_idx and i_cfg_data; write them only while no step is in flight. Indexes beyond the
// register list are dropped, and wide data is truncated to each register's width.
module heading_turn_pid_drive (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    htpd_in_if.sink                              i_item,
    htpd_out_if.source                           o_result,
    input  wire logic                            i_cfg_we,
    input  wire logic [htpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [htpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import htpd_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // Register file: each write to a listed index lands in one field, truncated to its width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_P:       r_cfg.gain_p             <= i_cfg_data;
                REG_GAIN_I:       r_cfg.gain_i             <= i_cfg_data;
                REG_GAIN_D:       r_cfg.gain_d             <= i_cfg_data;
                REG_DEADBAND:     r_cfg.deadband_tenths    <= i_cfg_data[MAG_W-1:0];
                REG_STRONG_ZONE:  r_cfg.strong_zone_tenths <= i_cfg_data[MAG_W-1:0];
                REG_FINE_FLOOR:   r_cfg.fine_floor         <= i_cfg_data[PWM_W-1:0];
                REG_FINE_CEILING: r_cfg.fine_ceiling       <= i_cfg_data[PWM_W-1:0];
                REG_STRONG_FLOOR: r_cfg.strong_floor       <= i_cfg_data[PWM_W-1:0];
                default: ;
            endcase
        end
    end

    // Step sequencer: takes a transfer only when idle, holds a pending result
    htpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Arithmetic and PID history; the output register lives here
    htpd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_target_heading   (i_item.target_heading),
        .i_measured_heading (i_item.measured_heading),
        .i_now_ms           (i_item.now_ms),
        .i_restart          (i_item.restart),
        .o_drive_pwm        (o_result.drive_pwm),
        .o_turn_dir         (o_result.turn_dir),
        .o_wrapped_error    (o_result.wrapped_error)
    );

endmodule
`default_nettype wire
